// ----- hdl/euler_rigid_point_transform_unit_defines.svh -----
`ifndef EULER_RIGID_POINT_TRANSFORM_UNIT_DEFINES_SVH
`define EULER_RIGID_POINT_TRANSFORM_UNIT_DEFINES_SVH

// same-cycle implication
`define ERPT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erpt: same-cycle check failed");

// next-cycle implication
`define ERPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erpt: next-cycle check failed");

`endif

// ----- hdl/erpt_pkg.sv -----
package erpt_pkg;

   localparam int ENTRY_WIDTH = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [ENTRY_WIDTH-1:0] ENTRY_ONE = 30'sd268435456;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef entry_type [8:0] matrix_type;

   typedef enum logic [2:0] {
      REG_YAW      = 3'd0,
      REG_PITCH    = 3'd1,
      REG_ROLL     = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      BLD_IDLE,
      BLD_LOAD,
      BLD_ROTATE,
      BLD_MULTIPLY,
      BLD_ROUND,
      BLD_STORE
   } build_state_type;

   // order of the trig products feeding the matrix
   typedef enum logic [3:0] {
      PS_CASB, PS_SASB, PS_R11, PS_R12A, PS_R12B, PS_R13A, PS_R13B,
      PS_R21, PS_R22A, PS_R22B, PS_R23A, PS_R23B, PS_R32, PS_R33
   } prod_step_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // arctan(2^-i) in 2^32 units per turn
   function automatic logic signed [33:0] arc_angle(input logic [4:0] i);
      logic signed [33:0] a;
      case (i)
         5'd0:  a = 34'sd536870912;
         5'd1:  a = 34'sd316933406;
         5'd2:  a = 34'sd167458907;
         5'd3:  a = 34'sd85004756;
         5'd4:  a = 34'sd42667331;
         5'd5:  a = 34'sd21354465;
         5'd6:  a = 34'sd10679838;
         5'd7:  a = 34'sd5340245;
         5'd8:  a = 34'sd2670163;
         5'd9:  a = 34'sd1335087;
         5'd10: a = 34'sd667544;
         5'd11: a = 34'sd333772;
         5'd12: a = 34'sd166886;
         5'd13: a = 34'sd83443;
         5'd14: a = 34'sd41722;
         5'd15: a = 34'sd20861;
         5'd16: a = 34'sd10430;
         5'd17: a = 34'sd5215;
         5'd18: a = 34'sd2608;
         5'd19: a = 34'sd1304;
         5'd20: a = 34'sd652;
         5'd21: a = 34'sd326;
         5'd22: a = 34'sd163;
         5'd23: a = 34'sd81;
         default: a = 34'sd0;
      endcase
      return a;
   endfunction

   // q30 sum to q28 entry, rounded and clamped to plus or minus one
   function automatic entry_type to_entry(input logic signed [33:0] v);
      logic signed [33:0] r;
      entry_type e;
      r = (v + 34'sd2) >>> 2;
      if (r > 34'sd268435456) begin
         e = ENTRY_ONE;
      end else if (r < -34'sd268435456) begin
         e = -ENTRY_ONE;
      end else begin
         e = r[ENTRY_WIDTH-1:0];
      end
      return e;
   endfunction

endpackage

// ----- hdl/erpt_rot_builder.sv -----
module erpt_rot_builder #(
   parameter int COORD_WIDTH  = 32,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16,
   parameter int WDATA_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [WDATA_WIDTH-1:0]        csr_wdata,
   output logic                          busy,
   output erpt_pkg::matrix_type          matrix,
   output logic signed [COORD_WIDTH-1:0] offset_x,
   output logic signed [COORD_WIDTH-1:0] offset_y,
   output logic signed [COORD_WIDTH-1:0] offset_z
);

   localparam int STEP_BITS = $clog2(CORDIC_STEPS);

   erpt_pkg::build_state_type state_ff, state_in;
   erpt_pkg::prod_step_type   prod_sel_ff;

   logic [ANGLE_WIDTH-1:0]   yaw_ff, pitch_ff, roll_ff;
   logic signed [COORD_WIDTH-1:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic [1:0]               angle_sel_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic signed [31:0]       x_ff, y_ff;
   logic signed [33:0]       z_ff;
   logic                     flip_ff;
   logic signed [31:0]       cos_ff [3];
   logic signed [31:0]       sin_ff [3];
   logic signed [63:0]       prod_ff;
   logic signed [31:0]       part_ff [14];
   erpt_pkg::matrix_type     matrix_ff;

   logic                     reg_write;
   logic                     load_en, rotate_en, mult_en, round_en, store_en;
   logic                     last_step, last_angle, last_prod;
   logic [ANGLE_WIDTH-1:0]   angle_cur;
   logic [31:0]              turn_bits;
   logic signed [33:0]       z_start;
   logic signed [31:0]       xs, ys, nx, ny;
   logic signed [33:0]       nz, arc;
   logic signed [31:0]       op_a, op_b;
   logic signed [63:0]       rounded;

   assign reg_write  = csr_write && (csr_index <= erpt_pkg::REG_OFFSET_Z);
   assign last_step  = (step_ff == STEP_BITS'(CORDIC_STEPS - 1));
   assign last_angle = (angle_sel_ff == 2'd2);
   assign last_prod  = (prod_sel_ff == erpt_pkg::PS_R33);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         erpt_pkg::BLD_IDLE:     state_in = erpt_pkg::BLD_IDLE;
         erpt_pkg::BLD_LOAD:     state_in = erpt_pkg::BLD_ROTATE;
         erpt_pkg::BLD_ROTATE: begin
            if (last_step) begin
               state_in = last_angle ? erpt_pkg::BLD_MULTIPLY : erpt_pkg::BLD_LOAD;
            end
         end
         erpt_pkg::BLD_MULTIPLY: state_in = erpt_pkg::BLD_ROUND;
         erpt_pkg::BLD_ROUND: begin
            state_in = last_prod ? erpt_pkg::BLD_STORE : erpt_pkg::BLD_MULTIPLY;
         end
         erpt_pkg::BLD_STORE:    state_in = erpt_pkg::BLD_IDLE;
         default:                state_in = erpt_pkg::BLD_IDLE;
      endcase
      if (reg_write) begin
         state_in = erpt_pkg::BLD_LOAD;
      end
   end

   // outputs of the sequencer
   always_comb begin
      load_en   = 1'b0;
      rotate_en = 1'b0;
      mult_en   = 1'b0;
      round_en  = 1'b0;
      store_en  = 1'b0;
      case (state_ff)
         erpt_pkg::BLD_LOAD:     load_en   = 1'b1;
         erpt_pkg::BLD_ROTATE:   rotate_en = 1'b1;
         erpt_pkg::BLD_MULTIPLY: mult_en   = 1'b1;
         erpt_pkg::BLD_ROUND:    round_en  = 1'b1;
         erpt_pkg::BLD_STORE:    store_en  = 1'b1;
         default:                load_en   = 1'b0;
      endcase
   end

   always_comb begin
      case (angle_sel_ff)
         2'd0:    angle_cur = yaw_ff;
         2'd1:    angle_cur = pitch_ff;
         default: angle_cur = roll_ff;
      endcase
   end

   // angle to 2^32 per turn; the fold into the right half plane is done at load
   always_comb begin
      turn_bits = {angle_cur, {(32 - ANGLE_WIDTH){1'b0}}};
      z_start   = 34'($signed(turn_bits));
   end

   assign arc = erpt_pkg::arc_angle(5'(step_ff));
   assign xs  = x_ff >>> step_ff;
   assign ys  = y_ff >>> step_ff;

   always_comb begin
      if (z_ff >= 34'sd0) begin
         nx = x_ff - ys;
         ny = y_ff + xs;
         nz = z_ff - arc;
      end else begin
         nx = x_ff + ys;
         ny = y_ff - xs;
         nz = z_ff + arc;
      end
   end

   always_comb begin
      op_a = cos_ff[0];
      op_b = cos_ff[1];
      case (prod_sel_ff)
         erpt_pkg::PS_CASB: begin op_a = cos_ff[0];  op_b = sin_ff[1]; end
         erpt_pkg::PS_SASB: begin op_a = sin_ff[0];  op_b = sin_ff[1]; end
         erpt_pkg::PS_R11:  begin op_a = cos_ff[0];  op_b = cos_ff[1]; end
         erpt_pkg::PS_R12A: begin op_a = part_ff[0]; op_b = sin_ff[2]; end
         erpt_pkg::PS_R12B: begin op_a = sin_ff[0];  op_b = cos_ff[2]; end
         erpt_pkg::PS_R13A: begin op_a = part_ff[0]; op_b = cos_ff[2]; end
         erpt_pkg::PS_R13B: begin op_a = sin_ff[0];  op_b = sin_ff[2]; end
         erpt_pkg::PS_R21:  begin op_a = sin_ff[0];  op_b = cos_ff[1]; end
         erpt_pkg::PS_R22A: begin op_a = part_ff[1]; op_b = sin_ff[2]; end
         erpt_pkg::PS_R22B: begin op_a = cos_ff[0];  op_b = cos_ff[2]; end
         erpt_pkg::PS_R23A: begin op_a = part_ff[1]; op_b = cos_ff[2]; end
         erpt_pkg::PS_R23B: begin op_a = cos_ff[0];  op_b = sin_ff[2]; end
         erpt_pkg::PS_R32:  begin op_a = cos_ff[1];  op_b = sin_ff[2]; end
         erpt_pkg::PS_R33:  begin op_a = cos_ff[1];  op_b = cos_ff[2]; end
         default:           begin op_a = cos_ff[0];  op_b = cos_ff[1]; end
      endcase
   end

   assign rounded = (prod_ff + 64'sd536870912) >>> 30;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= erpt_pkg::BLD_IDLE;
         yaw_ff      <= '0;
         pitch_ff    <= '0;
         roll_ff     <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         offset_z_ff <= '0;
         matrix_ff   <= '0;
         matrix_ff[0] <= erpt_pkg::ENTRY_ONE;
         matrix_ff[4] <= erpt_pkg::ENTRY_ONE;
         matrix_ff[8] <= erpt_pkg::ENTRY_ONE;
         angle_sel_ff <= '0;
         step_ff      <= '0;
         prod_sel_ff  <= erpt_pkg::PS_CASB;
      end else begin
         state_ff <= state_in;
         if (reg_write) begin
            angle_sel_ff <= '0;
            case (csr_index)
               erpt_pkg::REG_YAW:      yaw_ff      <= csr_wdata[ANGLE_WIDTH-1:0];
               erpt_pkg::REG_PITCH:    pitch_ff    <= csr_wdata[ANGLE_WIDTH-1:0];
               erpt_pkg::REG_ROLL:     roll_ff     <= csr_wdata[ANGLE_WIDTH-1:0];
               erpt_pkg::REG_OFFSET_X: offset_x_ff <= csr_wdata[COORD_WIDTH-1:0];
               erpt_pkg::REG_OFFSET_Y: offset_y_ff <= csr_wdata[COORD_WIDTH-1:0];
               erpt_pkg::REG_OFFSET_Z: offset_z_ff <= csr_wdata[COORD_WIDTH-1:0];
               default:                yaw_ff      <= yaw_ff;
            endcase
         end else begin
            if (load_en) begin
               step_ff <= '0;
            end
            if (rotate_en) begin
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  if (last_angle) begin
                     prod_sel_ff <= erpt_pkg::PS_CASB;
                  end else begin
                     angle_sel_ff <= angle_sel_ff + 1'b1;
                  end
               end
            end
            if (round_en && !last_prod) begin
               prod_sel_ff <= erpt_pkg::prod_step_type'(prod_sel_ff + 1'b1);
            end
            if (store_en) begin
               matrix_ff[0] <= erpt_pkg::to_entry(34'(part_ff[2]));
               matrix_ff[1] <= erpt_pkg::to_entry(34'(part_ff[3]) - 34'(part_ff[4]));
               matrix_ff[2] <= erpt_pkg::to_entry(34'(part_ff[5]) + 34'(part_ff[6]));
               matrix_ff[3] <= erpt_pkg::to_entry(34'(part_ff[7]));
               matrix_ff[4] <= erpt_pkg::to_entry(34'(part_ff[8]) + 34'(part_ff[9]));
               matrix_ff[5] <= erpt_pkg::to_entry(34'(part_ff[10]) - 34'(part_ff[11]));
               matrix_ff[6] <= erpt_pkg::to_entry(-34'(sin_ff[1]));
               matrix_ff[7] <= erpt_pkg::to_entry(34'(part_ff[12]));
               matrix_ff[8] <= erpt_pkg::to_entry(34'(part_ff[13]));
            end
         end
      end
   end

   // cordic and product datapath
   always_ff @(posedge clock) begin
      if (load_en) begin
         x_ff    <= erpt_pkg::CORDIC_GAIN;
         y_ff    <= '0;
         flip_ff <= 1'b0;
         z_ff    <= z_start;
         if (z_start > 34'sd1073741824) begin
            z_ff    <= z_start - 34'sd2147483648;
            flip_ff <= 1'b1;
         end else if (z_start < -34'sd1073741824) begin
            z_ff    <= z_start + 34'sd2147483648;
            flip_ff <= 1'b1;
         end
      end
      if (rotate_en) begin
         x_ff <= nx;
         y_ff <= ny;
         z_ff <= nz;
         if (last_step) begin
            cos_ff[angle_sel_ff] <= flip_ff ? -nx : nx;
            sin_ff[angle_sel_ff] <= flip_ff ? -ny : ny;
         end
      end
      if (mult_en) begin
         prod_ff <= 64'(op_a) * 64'(op_b);
      end
      if (round_en) begin
         part_ff[prod_sel_ff] <= rounded[31:0];
      end
   end

   assign busy     = (state_ff != erpt_pkg::BLD_IDLE);
   assign matrix   = matrix_ff;
   assign offset_x = offset_x_ff;
   assign offset_y = offset_y_ff;
   assign offset_z = offset_z_ff;

endmodule

// ----- hdl/erpt_point_queue.sv -----
module erpt_point_queue #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   output logic                          q_valid,
   input  logic                          q_take,
   output logic signed [COORD_WIDTH-1:0] q_point_x,
   output logic signed [COORD_WIDTH-1:0] q_point_y,
   output logic signed [COORD_WIDTH-1:0] q_point_z,
   output erpt_pkg::queue_status_type    status
);

   logic signed [COORD_WIDTH-1:0] x_ff [erpt_pkg::QUEUE_DEPTH];
   logic signed [COORD_WIDTH-1:0] y_ff [erpt_pkg::QUEUE_DEPTH];
   logic signed [COORD_WIDTH-1:0] z_ff [erpt_pkg::QUEUE_DEPTH];
   logic [erpt_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [erpt_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic push, pop, full;

   assign full      = (count_ff == (erpt_pkg::QUEUE_PTR_BITS + 1)'(erpt_pkg::QUEUE_DEPTH));
   // no new item while the matrix is being rebuilt
   assign req_stall = full || hold;
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_take;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         x_ff[wr_ptr_ff] <= req_point_x;
         y_ff[wr_ptr_ff] <= req_point_y;
         z_ff[wr_ptr_ff] <= req_point_z;
      end
   end

   assign q_point_x    = x_ff[rd_ptr_ff];
   assign q_point_y    = y_ff[rd_ptr_ff];
   assign q_point_z    = z_ff[rd_ptr_ff];
   assign status.full  = full;
   assign status.empty = !q_valid;

endmodule

// ----- hdl/erpt_point_mac.sv -----
module erpt_point_mac #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  erpt_pkg::matrix_type          matrix,
   input  logic signed [COORD_WIDTH-1:0] offset_x,
   input  logic signed [COORD_WIDTH-1:0] offset_y,
   input  logic signed [COORD_WIDTH-1:0] offset_z,
   input  logic                          q_valid,
   output logic                          q_take,
   input  logic signed [COORD_WIDTH-1:0] q_point_x,
   input  logic signed [COORD_WIDTH-1:0] q_point_y,
   input  logic signed [COORD_WIDTH-1:0] q_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_x,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_y,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_z,
   output logic                          rsp_clipped
);

   localparam int PW = COORD_WIDTH + erpt_pkg::ENTRY_WIDTH;
   localparam int SW = PW + 2;
   localparam int RW = SW - 28;
   localparam int OW = RW + 1;

   logic signed [PW-1:0] prod_ff [9];
   logic signed [PW-1:0] prod_in [9];
   logic signed [RW-1:0] row_ff  [3];
   logic signed [RW-1:0] row_in  [3];
   logic signed [SW-1:0] sum     [3];
   logic signed [OW-1:0] full_val [3];
   logic signed [COORD_WIDTH-1:0] sat [3];
   logic [2:0]           over;
   logic signed [COORD_WIDTH-1:0] pt  [3];
   logic signed [COORD_WIDTH-1:0] off [3];
   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;
   logic signed [COORD_WIDTH-1:0] moved_ff [3];
   logic clipped_ff;

   assign pt[0]  = q_point_x;
   assign pt[1]  = q_point_y;
   assign pt[2]  = q_point_z;
   assign off[0] = offset_x;
   assign off[1] = offset_y;
   assign off[2] = offset_z;

   assign ready3 = !v3_ff || !rsp_stall;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign q_take = ready1;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         prod_in[i] = PW'($signed(matrix[i])) * PW'(pt[i % 3]);
      end
   end

   // floor((sum + half) / 2^28), exact
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum[r] = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2])
                  + (SW'(1) <<< 27);
         row_in[r] = sum[r][SW-1:28];
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         full_val[r] = OW'(row_ff[r]) + OW'(off[r]);
         over[r] = (full_val[r][OW-1:COORD_WIDTH-1] != {(OW - COORD_WIDTH + 1){1'b0}})
                && (full_val[r][OW-1:COORD_WIDTH-1] != {(OW - COORD_WIDTH + 1){1'b1}});
         if (!over[r]) begin
            sat[r] = full_val[r][COORD_WIDTH-1:0];
         end else if (full_val[r][OW-1]) begin
            sat[r] = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
         end else begin
            sat[r] = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= q_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && q_valid) begin
         prod_ff <= prod_in;
      end
      if (ready2 && v1_ff) begin
         row_ff <= row_in;
      end
      if (ready3 && v2_ff) begin
         moved_ff   <= sat;
         clipped_ff <= |over;
      end
   end

   assign rsp_valid   = v3_ff;
   assign rsp_moved_x = moved_ff[0];
   assign rsp_moved_y = moved_ff[1];
   assign rsp_moved_z = moved_ff[2];
   assign rsp_clipped = clipped_ff;

endmodule

// ----- hdl/euler_rigid_point_transform_unit.sv -----
// Euler z-y-x rigid transform of a stream of points: moved = R * point + offset.
// csr port: write yaw, pitch, roll (binary angles, one turn = 2^ANGLE_WIDTH) and
//   the three offsets by index; a write to any of these six starts a rebuild of
//   the cached matrix, sin and cos by a shared cordic, then fourteen products on
//   one multiplier. req_stall stays high while the rebuild runs. Write only while
//   no point is in flight.
// req channel: one point per item, taken at an edge with req_valid and !req_stall.
//   Points go into a four-entry queue, so the input keeps flowing for a few
//   items when the result side stalls.
// rsp channel: moved point plus clipped, set when any coordinate saturated.
// Throughput is one point per cycle while neither rsp_stall nor a rebuild holds
//   the flow, set by the nine parallel multipliers of the back end.
// rsp_stall freezes the three back-end stages and the queue then fills;
//   req_stall rises once the queue is full.
// Reset (synchronous) zeroes the registers, loads the exact identity matrix and
//   empties the queue and pipeline.
`include "euler_rigid_point_transform_unit_defines.svh"

module euler_rigid_point_transform_unit #(
   parameter int COORD_WIDTH  = 32,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16,
   parameter int WDATA_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [WDATA_WIDTH-1:0]        csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_x,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_y,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_z,
   output logic                          rsp_clipped
);

   logic                          build_busy;
   erpt_pkg::matrix_type          matrix;
   logic signed [COORD_WIDTH-1:0] offset_x, offset_y, offset_z;
   logic                          q_valid, q_take;
   logic signed [COORD_WIDTH-1:0] q_point_x, q_point_y, q_point_z;
   erpt_pkg::queue_status_type    queue_status;

   erpt_rot_builder #(
      .COORD_WIDTH  (COORD_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS),
      .WDATA_WIDTH  (WDATA_WIDTH)
   ) u_builder (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (build_busy),
      .matrix    (matrix),
      .offset_x  (offset_x),
      .offset_y  (offset_y),
      .offset_z  (offset_z)
   );

   erpt_point_queue #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .hold        (build_busy),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_point_x   (q_point_x),
      .q_point_y   (q_point_y),
      .q_point_z   (q_point_z),
      .status      (queue_status)
   );

   erpt_point_mac #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .matrix      (matrix),
      .offset_x    (offset_x),
      .offset_y    (offset_y),
      .offset_z    (offset_z),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_point_x   (q_point_x),
      .q_point_y   (q_point_y),
      .q_point_z   (q_point_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_moved_x (rsp_moved_x),
      .rsp_moved_y (rsp_moved_y),
      .rsp_moved_z (rsp_moved_z),
      .rsp_clipped (rsp_clipped)
   );

   `ERPT_ASSERT_NEXT(a_write_starts_build, clock, reset, csr_write && (csr_index <= erpt_pkg::REG_OFFSET_Z), build_busy)
   `ERPT_ASSERT_IMPLIES(a_no_accept_in_build, clock, reset, build_busy, req_stall)
   `ERPT_ASSERT_IMPLIES(a_empty_queue_no_take, clock, reset, queue_status.empty, !q_valid)

endmodule

// ----- bench/euler_rigid_point_transform_unit_test.sv -----
module euler_rigid_point_transform_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [2:0] SPARE_INDEX_A = 3'd6;
   localparam logic [2:0] SPARE_INDEX_B = 3'd7;
   localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
   localparam longint ARC_STEP[16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861
   };

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               clip;
   } moved_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_moved_x;
   logic signed [31:0] rsp_moved_y;
   logic signed [31:0] rsp_moved_z;
   logic rsp_clipped;

   // shadow of the block's registers and cached matrix
   logic [15:0] angle_reg[3];
   logic signed [31:0] offset_reg[3];
   longint rot[9];

   moved_point_type pending_moves[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;

   euler_rigid_point_transform_unit i_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_moved_x(rsp_moved_x), .rsp_moved_y(rsp_moved_y), .rsp_moved_z(rsp_moved_z),
      .rsp_clipped(rsp_clipped)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint mul_q30(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic longint q30_to_entry(input longint v);
      longint r;
      r = (v + 2) >>> 2;
      if (r > 64'sd268435456) r = 64'sd268435456;
      if (r < -64'sd268435456) r = -64'sd268435456;
      return r;
   endfunction

   task automatic cordic_sin_cos(input logic [15:0] ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = longint'($signed({ang, 16'h0000}));
      x = longint'(erpt_pkg::CORDIC_GAIN);
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ARC_STEP[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ARC_STEP[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic rebuild_rotation();
      longint ca, sa, cb, sb, cg, sg, casb, sasb;
      cordic_sin_cos(angle_reg[0], ca, sa);
      cordic_sin_cos(angle_reg[1], cb, sb);
      cordic_sin_cos(angle_reg[2], cg, sg);
      casb = mul_q30(ca, sb);
      sasb = mul_q30(sa, sb);
      rot[0] = q30_to_entry(mul_q30(ca, cb));
      rot[1] = q30_to_entry(mul_q30(casb, sg) - mul_q30(sa, cg));
      rot[2] = q30_to_entry(mul_q30(casb, cg) + mul_q30(sa, sg));
      rot[3] = q30_to_entry(mul_q30(sa, cb));
      rot[4] = q30_to_entry(mul_q30(sasb, sg) + mul_q30(ca, cg));
      rot[5] = q30_to_entry(mul_q30(sasb, cg) - mul_q30(ca, sg));
      rot[6] = q30_to_entry(-sb);
      rot[7] = q30_to_entry(mul_q30(cb, sg));
      rot[8] = q30_to_entry(mul_q30(cb, cg));
   endtask

   function automatic moved_point_type transform_point(input logic signed [31:0] px,
                                                       input logic signed [31:0] py,
                                                       input logic signed [31:0] pz);
      moved_point_type m;
      longint p[3], hs, ls, hi, lo, r;
      logic signed [31:0] res[3];
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      m.clip = 1'b0;
      for (int k = 0; k < 3; k++) begin
         hs = 0;
         ls = 0;
         for (int j = 0; j < 3; j++) begin
            hi = p[j] >>> 16;
            lo = p[j] - hi * 65536;
            hs += hi * rot[3 * k + j];
            ls += lo * rot[3 * k + j];
         end
         r = ((hs + (ls >>> 16) + 2048) >>> 12) + longint'(offset_reg[k]);
         if (r > longint'(COORD_MAX)) begin
            r = COORD_MAX;
            m.clip = 1'b1;
         end else if (r < longint'(COORD_MIN)) begin
            r = COORD_MIN;
            m.clip = 1'b1;
         end
         res[k] = r[31:0];
      end
      m.x = res[0];
      m.y = res[1];
      m.z = res[2];
      return m;
   endfunction

   // called at a rising edge with the block idle
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx <= erpt_pkg::REG_ROLL) begin
         angle_reg[idx] = value[15:0];
         rebuild_rotation();
      end else if (idx <= erpt_pkg::REG_OFFSET_Z) begin
         offset_reg[idx - erpt_pkg::REG_OFFSET_X] = value;
         rebuild_rotation();
      end
      // let the matrix rebuild finish
      repeat (2) @(posedge clock);
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] pz);
      bit taken;
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pending_moves.push_back(transform_point(px, py, pz));
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_moves.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
         2: return $signed($urandom_range(0, 536870912)) - 32'sd268435456;
         3: begin
            case ($urandom_range(0, 3))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
      endcase
   endfunction

   function automatic logic [31:0] random_offset();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return $urandom;
         default: return $signed($urandom_range(0, 8388608)) - 32'sd4194304;
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) send_point(random_coord(), random_coord(), random_coord());
   endtask

   task automatic test_reset_matrix();
      send_point(32'sd0, 32'sd0, 32'sd0);
      send_point(COORD_MAX, COORD_MIN, -32'sd1);
      send_point(COORD_MIN, COORD_MAX, 32'sd65536);
      send_point(32'sd1, -32'sd65536, COORD_MAX);
      send_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      // zero angles through the cordic, not the exact reset identity
      write_reg(erpt_pkg::REG_YAW, 32'h0000_0000);
      send_point(COORD_MAX, COORD_MIN, 32'sd12345678);
      wait_drained();
      // half turn, upper data bits set to check truncation
      write_reg(erpt_pkg::REG_YAW, 32'hffff_8000);
      write_reg(erpt_pkg::REG_PITCH, 32'h0000_7fff);
      write_reg(erpt_pkg::REG_ROLL, 32'h1234_4000);
      send_point(32'sd65536, 32'sd131072, -32'sd196608);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      wait_drained();
      write_reg(erpt_pkg::REG_OFFSET_X, COORD_MAX);
      write_reg(erpt_pkg::REG_OFFSET_Y, COORD_MIN);
      write_reg(erpt_pkg::REG_OFFSET_Z, 32'h0001_0000);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, 32'sd0, COORD_MAX);
      send_point(32'sd0, 32'sd0, 32'sd0);
      wait_drained();
      // unknown indexes leave everything as it is
      write_reg(SPARE_INDEX_A, $urandom);
      write_reg(SPARE_INDEX_B, $urandom);
      send_point(32'sd1, -32'sd1, 32'sd65536);
      wait_drained();
      write_reg(erpt_pkg::REG_PITCH, 32'h0000_8000);
      write_reg(erpt_pkg::REG_ROLL, 32'h0000_c000);
      send_point(-32'sd65536, 32'sd1048576, COORD_MAX);
      send_point(32'shffff0000, 32'sh0000ffff, 32'sh7fff0000);
      wait_drained();
   endtask

   task automatic test_random_poses(input int phases, input int per_phase);
      for (int ph = 0; ph < phases; ph++) begin
         for (int r = erpt_pkg::REG_YAW; r <= erpt_pkg::REG_OFFSET_Z; r++) begin
            if (r <= erpt_pkg::REG_ROLL) write_reg(3'(r), $urandom);
            else write_reg(3'(r), random_offset());
         end
         send_random(per_phase);
         wait_drained();
      end
   endtask

   task automatic test_result_holdoff();
      long_hold = 1'b1;
      send_random(24);
      wait_drained();
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      write_reg(erpt_pkg::REG_YAW, $urandom);
      send_random(40);
      wait_drained();
   endtask

   // receiver side: random stall bursts, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin : check_moves
      moved_point_type m;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_moves.size() == 0) begin
            $error("item with no point pending");
            errors++;
         end else begin
            m = pending_moves.pop_front();
            if (rsp_moved_x !== m.x) begin
               $error("moved_x expected %0d got %0d", m.x, rsp_moved_x);
               errors++;
            end
            if (rsp_moved_y !== m.y) begin
               $error("moved_y expected %0d got %0d", m.y, rsp_moved_y);
               errors++;
            end
            if (rsp_moved_z !== m.z) begin
               $error("moved_z expected %0d got %0d", m.z, rsp_moved_z);
               errors++;
            end
            if (rsp_clipped !== m.clip) begin
               $error("clipped expected %0b got %0b", m.clip, rsp_clipped);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < 3; k++) begin
         angle_reg[k] = '0;
         offset_reg[k] = '0;
      end
      for (int k = 0; k < 9; k++) rot[k] = (k % 4 == 0) ? 64'sd268435456 : 64'sd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      test_reset_matrix();
      test_register_extremes();
      test_random_poses(6, 95);
      test_result_holdoff();
      test_steady_stream();
      if (pending_moves.size() != 0) begin
         $error("%0d points never came back", pending_moves.size());
         errors++;
      end
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/erpt_pkg.sv
hdl/erpt_rot_builder.sv
hdl/erpt_point_queue.sv
hdl/erpt_point_mac.sv
hdl/euler_rigid_point_transform_unit.sv
bench/euler_rigid_point_transform_unit_test.sv
